// File: design/cpra_pkg.sv
`timescale 1ns / 1ps

package cpra_pkg;

  localparam int PAGE_W     = 52;
  localparam int LEN_W      = 32;
  localparam int CFG_DATA_W = 52;

  localparam logic [PAGE_W-1:0] RESET_POOL_START = 52'd256;
  localparam logic [LEN_W-1:0]  RESET_POOL_COUNT = 32'd262144;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic {
    CFG_POOL_START = 1'b0,
    CFG_POOL_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EXCEEDS = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // found flags of one table scan
  typedef struct packed {
    logic best;
    logic merge;
    logic same;
    logic slot;
  } scan_flags_t;

endpackage

// File: design/cpra_run_table.sv
`timescale 1ns / 1ps

module cpra_run_table #(
  parameter int DEPTH = 64,
  parameter int IW    = 6,
  parameter int DW    = 85
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [IW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [IW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/cpra_alu.sv
`timescale 1ns / 1ps

module cpra_alu
  import cpra_pkg::*;
#(
  parameter int W = 52
) (
  input  logic [W-1:0]     a_i,
  input  logic [W-1:0]     b_i,
  input  logic             sub_i,
  output logic [W:0]       res_o,
  output logic [LEN_W-1:0] sat_o
);

  // top bit is the carry on add and the borrow on subtract
  assign res_o = sub_i ? ({1'b0, a_i} - {1'b0, b_i}) : ({1'b0, a_i} + {1'b0, b_i});

  // saturated sum of two run lengths
  assign sat_o = res_o[LEN_W] ? {LEN_W{1'b1}} : res_o[LEN_W-1:0];

endmodule

// File: design/cpra_scan.sv
`timescale 1ns / 1ps

module cpra_scan
  import cpra_pkg::*;
#(
  parameter int IW  = 6,
  parameter int PNB = 52
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             vld_i,
  input  logic [IW-1:0]    idx_i,
  input  logic             free_i,
  input  logic             ent_valid_i,
  input  logic [PNB-1:0]   ent_begin_i,
  input  logic [LEN_W-1:0] ent_len_i,
  input  logic [LEN_W-1:0] count_i,
  input  logic [PNB-1:0]   start_i,
  input  logic [PNB-1:0]   end_i,
  output scan_flags_t      flags_o,
  output logic [IW-1:0]    best_idx_o,
  output logic [PNB-1:0]   best_begin_o,
  output logic [LEN_W-1:0] best_len_o,
  output logic [IW-1:0]    merge_idx_o,
  output logic [LEN_W-1:0] merge_len_o,
  output logic [IW-1:0]    same_idx_o,
  output logic [IW-1:0]    slot_idx_o
);

  scan_flags_t      flags_q;
  logic [IW-1:0]    best_idx_q;
  logic [PNB-1:0]   best_begin_q;
  logic [LEN_W-1:0] best_len_q;
  logic [IW-1:0]    merge_idx_q;
  logic [LEN_W-1:0] merge_len_q;
  logic [IW-1:0]    same_idx_q;
  logic [IW-1:0]    slot_idx_q;

  logic is_merge;
  logic live;
  logic qual;
  logic take_best;
  logic take_merge;
  logic take_same;
  logic take_slot;

  // the run that starts at the end of a freed range is folded in, so it
  // counts as gone for the predecessor, same-begin and slot searches
  always_comb begin
    is_merge   = free_i && ent_valid_i && (ent_begin_i == end_i);
    live       = ent_valid_i && !is_merge;
    qual       = free_i ? (live && (ent_begin_i < start_i))
                        : (ent_valid_i && (ent_len_i >= count_i));
    take_best  = qual && (!flags_q.best || (ent_begin_i > best_begin_q));
    take_merge = is_merge && !flags_q.merge;
    take_same  = live && (ent_begin_i == start_i);
    take_slot  = !live && !flags_q.slot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (clear_i) begin
      flags_q <= '0;
    end else if (vld_i) begin
      if (take_best)  flags_q.best  <= 1'b1;
      if (take_merge) flags_q.merge <= 1'b1;
      if (take_same)  flags_q.same  <= 1'b1;
      if (take_slot)  flags_q.slot  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      if (take_best) begin
        best_idx_q   <= idx_i;
        best_begin_q <= ent_begin_i;
        best_len_q   <= ent_len_i;
      end
      if (take_merge) begin
        merge_idx_q <= idx_i;
        merge_len_q <= ent_len_i;
      end
      if (take_same) begin
        same_idx_q <= idx_i;
      end
      if (take_slot) begin
        slot_idx_q <= idx_i;
      end
    end
  end

  assign flags_o      = flags_q;
  assign best_idx_o   = best_idx_q;
  assign best_begin_o = best_begin_q;
  assign best_len_o   = best_len_q;
  assign merge_idx_o  = merge_idx_q;
  assign merge_len_o  = merge_len_q;
  assign same_idx_o   = same_idx_q;
  assign slot_idx_o   = slot_idx_q;

endmodule

// File: design/contiguous_page_run_allocator.sv
`timescale 1ns / 1ps
// Channel   Transfer when              Ports
// -------   -------------------------  ------------------------------------------
// request   start && !busy            operation_i, range_start_i, page_count_i
// result    done_o (one cycle)         base_page_o, pool_recycled_o, status_o
// config    cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// Every request scans the run table once through its single read port, one entry
// per cycle; an allocate that recycles the pool then runs a clearing sweep over
// the table before its result.
// After reset a clearing pass over the table runs with busy high.
// busy stays high from the accepted request until its result strobe.
// The receiver cannot stall: done_o is a single-cycle strobe.

module contiguous_page_run_allocator
  import cpra_pkg::*;
#(
  parameter int MAX_RUNS         = 64,
  parameter int PAGE_NUMBER_BITS = 52
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  operation_i,
  input  logic [PAGE_W-1:0]     range_start_i,
  input  logic [LEN_W-1:0]      page_count_i,
  output logic                  done_o,
  output logic [PAGE_W-1:0]     base_page_o,
  output logic                  pool_recycled_o,
  output logic [1:0]            status_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int PNB = PAGE_NUMBER_BITS;
  localparam int IW  = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int EW  = 1 + PNB + LEN_W;
  localparam int AW  = (PNB > LEN_W + 1) ? PNB : LEN_W + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_RUNS - 1);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_SWEEP  = 11'b000_0000_0010,
    S_FEND   = 11'b000_0000_0100,
    S_SCAN   = 11'b000_0000_1000,
    S_A_SUB  = 11'b000_0001_0000,
    S_A_ADD  = 11'b000_0010_0000,
    S_R_SUB  = 11'b000_0100_0000,
    S_R_ADD  = 11'b000_1000_0000,
    S_F_SAT  = 11'b001_0000_0000,
    S_F_PEND = 11'b010_0000_0000,
    S_F_UPD  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic              init_q;
  logic [IW-1:0]     cnt_q;
  logic              issue_q;
  logic              dvld_q;
  logic [IW-1:0]     didx_q;
  logic              done_q;
  logic [PAGE_W-1:0] pool_start_q;
  logic [LEN_W-1:0]  pool_cnt_q;

  op_e               op_q;
  logic [PNB-1:0]    start_q;
  logic [LEN_W-1:0]  count_q;
  logic [PNB-1:0]    end_q;
  logic [LEN_W-1:0]  diff_q;
  logic [PNB-1:0]    base_q;
  logic              fits_q;
  logic [LEN_W-1:0]  cnt2_q;
  logic              pred_hit_q;
  logic [PAGE_W-1:0] out_base_q;
  logic              out_rec_q;
  status_e           out_status_q;

  // run table
  logic          tbl_we;
  logic [IW-1:0] tbl_waddr;
  logic [EW-1:0] tbl_wdata;
  logic          tbl_re;
  logic [EW-1:0] tbl_rdata;

  // shared adder
  logic [AW-1:0]    alu_a;
  logic [AW-1:0]    alu_b;
  logic             alu_sub;
  logic [AW:0]      alu_res;
  logic [LEN_W-1:0] alu_sat;

  // scan results
  logic             scan_clear;
  scan_flags_t      flags;
  logic [IW-1:0]    best_idx;
  logic [PNB-1:0]   best_begin;
  logic [LEN_W-1:0] best_len;
  logic [IW-1:0]    merge_idx;
  logic [LEN_W-1:0] merge_len;
  logic [IW-1:0]    same_idx;
  logic [IW-1:0]    slot_idx;

  logic scan_done;

  assign busy      = (state_q != S_IDLE);
  assign scan_done = !issue_q && !dvld_q;
  assign tbl_re    = (state_q == S_SCAN) && issue_q;
  assign scan_clear = ((state_q == S_IDLE) && start) || (state_q == S_FEND);

  cpra_run_table #(
    .DEPTH (MAX_RUNS),
    .IW    (IW),
    .DW    (EW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (cnt_q),
    .rdata_o (tbl_rdata)
  );

  cpra_scan #(
    .IW  (IW),
    .PNB (PNB)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (scan_clear),
    .vld_i        (dvld_q),
    .idx_i        (didx_q),
    .free_i       (op_q == OP_FREE),
    .ent_valid_i  (tbl_rdata[EW-1]),
    .ent_begin_i  (tbl_rdata[LEN_W +: PNB]),
    .ent_len_i    (tbl_rdata[LEN_W-1:0]),
    .count_i      (count_q),
    .start_i      (start_q),
    .end_i        (end_q),
    .flags_o      (flags),
    .best_idx_o   (best_idx),
    .best_begin_o (best_begin),
    .best_len_o   (best_len),
    .merge_idx_o  (merge_idx),
    .merge_len_o  (merge_len),
    .same_idx_o   (same_idx),
    .slot_idx_o   (slot_idx)
  );

  cpra_alu #(
    .W (AW)
  ) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .res_o (alu_res),
    .sat_o (alu_sat)
  );

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      S_FEND: begin
        alu_a = AW'(start_q);
        alu_b = AW'(count_q);
      end
      S_A_SUB: begin
        alu_a   = AW'(best_len);
        alu_b   = AW'(count_q);
        alu_sub = 1'b1;
      end
      S_A_ADD: begin
        alu_a = AW'(best_begin);
        alu_b = AW'(diff_q);
      end
      S_R_SUB: begin
        alu_a   = AW'(pool_cnt_q);
        alu_b   = AW'(count_q);
        alu_sub = 1'b1;
      end
      S_R_ADD: begin
        alu_a = AW'(PNB'(pool_start_q));
        alu_b = AW'(diff_q);
      end
      S_F_SAT: begin
        alu_a = AW'(count_q);
        alu_b = AW'(merge_len);
      end
      S_F_PEND: begin
        alu_a = AW'(best_begin);
        alu_b = AW'(best_len);
      end
      S_F_UPD: begin
        alu_a = AW'(best_len);
        alu_b = AW'(cnt2_q);
      end
      default: ;
    endcase
  end

  // table writes; entry layout is {valid, begin, length}
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = '0;
    tbl_wdata = '0;
    case (state_q)
      S_SWEEP: begin
        tbl_we    = 1'b1;
        tbl_waddr = cnt_q;
        if (cnt_q == '0) begin
          if (init_q) begin
            tbl_wdata = {1'b1, PNB'(RESET_POOL_START), RESET_POOL_COUNT};
          end else begin
            // entry 0 already carries the retried allocation
            tbl_wdata = {(!fits_q || (diff_q != '0)), PNB'(pool_start_q),
                         (fits_q ? diff_q : pool_cnt_q)};
          end
        end
      end
      S_A_ADD: begin
        tbl_we    = 1'b1;
        tbl_waddr = best_idx;
        tbl_wdata = {(diff_q != '0), best_begin, diff_q};
      end
      S_F_SAT: begin
        tbl_we    = flags.merge;
        tbl_waddr = merge_idx;
      end
      S_F_UPD: begin
        if (pred_hit_q) begin
          tbl_we    = 1'b1;
          tbl_waddr = best_idx;
          tbl_wdata = {1'b1, best_begin, alu_sat};
        end else if (flags.same) begin
          tbl_we    = 1'b1;
          tbl_waddr = same_idx;
          tbl_wdata = {1'b1, start_q, cnt2_q};
        end else if (flags.slot) begin
          tbl_we    = 1'b1;
          tbl_waddr = slot_idx;
          tbl_wdata = {1'b1, start_q, cnt2_q};
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = (operation_i == OP_ALLOC) ? S_SCAN : S_FEND;
        end
      end
      S_FEND: state_d = S_SCAN;
      S_SCAN: begin
        if (scan_done) begin
          if (op_q == OP_ALLOC) begin
            state_d = flags.best ? S_A_SUB : S_R_SUB;
          end else begin
            state_d = S_F_SAT;
          end
        end
      end
      S_A_SUB:  state_d = S_A_ADD;
      S_A_ADD:  state_d = S_IDLE;
      S_R_SUB:  state_d = S_R_ADD;
      S_R_ADD:  state_d = S_SWEEP;
      S_SWEEP: begin
        if (cnt_q == '0) begin
          state_d = S_IDLE;
        end
      end
      S_F_SAT:  state_d = S_F_PEND;
      S_F_PEND: state_d = S_F_UPD;
      S_F_UPD:  state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_SWEEP;
      init_q       <= 1'b1;
      cnt_q        <= LAST_IDX;
      issue_q      <= 1'b0;
      dvld_q       <= 1'b0;
      done_q       <= 1'b0;
      pool_start_q <= RESET_POOL_START;
      pool_cnt_q   <= RESET_POOL_COUNT;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      dvld_q  <= tbl_re;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_POOL_START: pool_start_q <= cfg_wdata_i;
          CFG_POOL_COUNT: pool_cnt_q   <= cfg_wdata_i[LEN_W-1:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (start && (operation_i == OP_ALLOC)) begin
            issue_q <= 1'b1;
            cnt_q   <= '0;
          end
        end
        S_FEND: begin
          issue_q <= 1'b1;
          cnt_q   <= '0;
        end
        S_SCAN: begin
          if (issue_q) begin
            if (cnt_q == LAST_IDX) begin
              issue_q <= 1'b0;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        S_R_ADD: begin
          init_q <= 1'b0;
          cnt_q  <= LAST_IDX;
        end
        S_SWEEP: begin
          if (cnt_q != '0) begin
            cnt_q <= cnt_q - 1'b1;
          end else begin
            init_q <= 1'b0;
            done_q <= !init_q;
          end
        end
        S_A_ADD, S_F_UPD: done_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    didx_q <= cnt_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_q    <= op_e'(operation_i);
          start_q <= PNB'(range_start_i);
          count_q <= page_count_i;
        end
      end
      S_FEND:  end_q <= alu_res[PNB-1:0];
      S_A_SUB: diff_q <= alu_res[LEN_W-1:0];
      S_A_ADD: begin
        out_base_q   <= PAGE_W'(alu_res[PNB-1:0]);
        out_rec_q    <= 1'b0;
        out_status_q <= ST_OK;
      end
      S_R_SUB: begin
        diff_q <= alu_res[LEN_W-1:0];
        fits_q <= !alu_res[AW];
      end
      S_R_ADD: base_q <= alu_res[PNB-1:0];
      S_SWEEP: begin
        if (cnt_q == '0) begin
          out_base_q   <= fits_q ? PAGE_W'(base_q) : '0;
          out_rec_q    <= 1'b1;
          out_status_q <= fits_q ? ST_OK : ST_EXCEEDS;
        end
      end
      S_F_SAT:  cnt2_q <= flags.merge ? alu_sat : count_q;
      S_F_PEND: pred_hit_q <= flags.best && (alu_res[PNB-1:0] == start_q);
      S_F_UPD: begin
        out_base_q   <= '0;
        out_rec_q    <= 1'b0;
        out_status_q <= (pred_hit_q || flags.same || flags.slot) ? ST_OK : ST_FULL;
      end
      default: ;
    endcase
  end

  assign done_o          = done_q;
  assign base_page_o     = out_base_q;
  assign pool_recycled_o = out_rec_q;
  assign status_o        = out_status_q;

endmodule

// File: design/cpra_checker.sv
`timescale 1ns / 1ps

module cpra_checker
  import cpra_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input logic [PAGE_W-1:0] base_page_o,
  input logic              pool_recycled_o,
  input logic [1:0]        status_o
);

  // an accepted request keeps the block busy until its result
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request transfer did not raise busy");

  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without a request in flight");

  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_error_base_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> (base_page_o == '0))
    else $error("failed request returned a base page");

  a_exceeds_recycled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_EXCEEDS)) |-> pool_recycled_o)
    else $error("oversize request without pool recycle");

endmodule

bind contiguous_page_run_allocator cpra_checker u_cpra_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .base_page_o     (base_page_o),
  .pool_recycled_o (pool_recycled_o),
  .status_o        (status_o)
);

// File: verif/tb_contiguous_page_run_allocator.sv
`timescale 1ns / 1ps

module tb_contiguous_page_run_allocator;
  import cpra_pkg::*;

  localparam int RUNS = 64;

  typedef struct packed {
    op_e               op;
    logic [PAGE_W-1:0] first;
    logic [LEN_W-1:0]  cnt;
  } req_t;

  typedef struct packed {
    logic              alloc;
    logic [LEN_W-1:0]  cnt;
    logic [PAGE_W-1:0] base;
    logic              recycled;
    status_e           st;
  } grant_t;

  typedef struct packed {
    logic [PAGE_W-1:0] base;
    logic [LEN_W-1:0]  cnt;
  } held_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic                  operation_i;
  logic [PAGE_W-1:0]     range_start_i;
  logic [LEN_W-1:0]      page_count_i;
  logic                  done_o;
  logic [PAGE_W-1:0]     base_page_o;
  logic                  pool_recycled_o;
  logic [1:0]            status_o;
  logic                  cfg_we_i;
  logic                  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  // shadow of the free-run table and pool registers
  logic [PAGE_W-1:0] run_first [RUNS];
  logic [LEN_W-1:0]  run_len   [RUNS];
  logic              run_live  [RUNS];
  logic [PAGE_W-1:0] pool_first;
  logic [LEN_W-1:0]  pool_len;

  req_t   request_q [$];
  grant_t grant_q   [$];
  held_t  held_q    [$];

  int unsigned issued   = 0;
  int unsigned accepted = 0;
  int unsigned err_cnt  = 0;
  int unsigned gap_pct  = 0;

  contiguous_page_run_allocator #(
    .MAX_RUNS        (RUNS),
    .PAGE_NUMBER_BITS(PAGE_W)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .range_start_i  (range_start_i),
    .page_count_i   (page_count_i),
    .done_o         (done_o),
    .base_page_o    (base_page_o),
    .pool_recycled_o(pool_recycled_o),
    .status_o       (status_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("[contiguous_page_run_allocator] ERROR");
    $finish;
  end

  function automatic void refill_pool();
    for (int i = 0; i < RUNS; i++) begin
      run_first[i] = '0;
      run_len[i]   = '0;
      run_live[i]  = 1'b0;
    end
    run_first[0] = pool_first;
    run_len[0]   = pool_len;
    run_live[0]  = 1'b1;
  endfunction

  // highest-starting live run that holds n pages
  function automatic int fit_index(logic [LEN_W-1:0] n);
    int best;
    best = -1;
    for (int i = 0; i < RUNS; i++) begin
      if (run_live[i] && run_len[i] >= n && (best < 0 || run_first[i] > run_first[best]))
        best = i;
    end
    return best;
  endfunction

  function automatic logic [LEN_W-1:0] sat_len(logic [LEN_W-1:0] a, logic [LEN_W-1:0] b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LEN_W] ? '1 : s[LEN_W-1:0];
  endfunction

  function automatic grant_t serve_request(req_t rq);
    grant_t            g;
    int                idx;
    int                pred;
    int                same;
    int                slot;
    logic [PAGE_W-1:0] tail;
    logic [LEN_W-1:0]  n;
    g          = '0;
    g.st       = ST_OK;
    g.cnt      = rq.cnt;
    g.alloc    = (rq.op == OP_ALLOC);
    n          = rq.cnt;
    if (rq.op == OP_ALLOC) begin
      idx = fit_index(n);
      if (idx < 0) begin
        refill_pool();
        g.recycled = 1'b1;
        idx = fit_index(n);
      end
      if (idx < 0) begin
        g.st = ST_EXCEEDS;
      end else begin
        g.base = run_first[idx] + PAGE_W'(run_len[idx] - n);
        if (run_len[idx] > n) run_len[idx] = run_len[idx] - n;
        else run_live[idx] = 1'b0;
      end
    end else begin
      // absorb a run starting right at the end of the freed range
      tail = rq.first + PAGE_W'(n);
      for (int i = 0; i < RUNS; i++) begin
        if (run_live[i] && run_first[i] == tail) begin
          n = sat_len(n, run_len[i]);
          run_live[i] = 1'b0;
          break;
        end
      end
      pred = -1;
      same = -1;
      slot = -1;
      for (int i = 0; i < RUNS; i++) begin
        if (!run_live[i]) begin
          if (slot < 0) slot = i;
        end else begin
          if (run_first[i] == rq.first) same = i;
          if (run_first[i] < rq.first && (pred < 0 || run_first[i] > run_first[pred]))
            pred = i;
        end
      end
      if (pred >= 0) tail = run_first[pred] + PAGE_W'(run_len[pred]);
      if (pred >= 0 && tail == rq.first) begin
        run_len[pred] = sat_len(run_len[pred], n);
      end else if (same >= 0) begin
        run_len[same] = n;
      end else if (slot >= 0) begin
        run_first[slot] = rq.first;
        run_len[slot]   = n;
        run_live[slot]  = 1'b1;
      end else begin
        g.st = ST_FULL;
      end
    end
    return g;
  endfunction

  function automatic req_t mk_req(op_e op, logic [PAGE_W-1:0] first, logic [LEN_W-1:0] cnt);
    req_t rq;
    rq.op    = op;
    rq.first = first;
    rq.cnt   = cnt;
    return rq;
  endfunction

  // mostly allocate/free of blocks actually handed out, some noise
  function automatic req_t random_request(bit scatter);
    req_t        rq;
    held_t       h;
    int unsigned k;
    int unsigned span;
    int unsigned dice;
    rq.op    = OP_ALLOC;
    rq.first = PAGE_W'({$urandom, $urandom});
    rq.cnt   = $urandom;
    dice     = $urandom_range(99);
    span     = (pool_len > 4) ? (pool_len >> 2) : 1;
    if (scatter) begin
      rq.op  = OP_FREE;
      rq.cnt = $urandom_range(1, 4);
    end else if (dice < 8) begin
      rq.op = op_e'($urandom_range(1));
    end else if (dice < 54 && held_q.size() != 0) begin
      k = $urandom_range(held_q.size() - 1);
      h = held_q[k];
      held_q.delete(k);
      rq.op    = OP_FREE;
      rq.first = h.base;
      rq.cnt   = h.cnt;
      // partial give-back leaves a fragment still held
      if (dice < 16 && h.cnt > 1) begin
        rq.cnt = $urandom_range(1, h.cnt - 1);
        held_q.push_back({h.base + PAGE_W'(rq.cnt), h.cnt - rq.cnt});
      end
    end else if (dice >= 54 && dice < 60) begin
      case (dice % 3)
        0:       rq.cnt = '0;
        1:       rq.cnt = pool_len;
        default: rq.cnt = pool_len + 1'b1;
      endcase
    end else begin
      rq.cnt = $urandom_range(1, span);
    end
    return rq;
  endfunction

  task automatic drain();
    while (request_q.size() != 0 || issued != accepted || grant_q.size() != 0 || busy)
      @(negedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == CFG_POOL_START) pool_first = val[PAGE_W-1:0];
    else pool_len = val[LEN_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic feed(int n, int unsigned gap, bit scatter);
    gap_pct = gap;
    for (int k = 0; k < n; k++) begin
      while (request_q.size() > 1) @(negedge clk_i);
      request_q.push_back(random_request(scatter));
    end
    drain();
  endtask

  // request driver
  always @(negedge clk_i) begin
    req_t cur;
    if (rst_ni && issued == accepted) begin
      if (request_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        cur = request_q[0];
        request_q.delete(0);
        operation_i   <= cur.op;
        range_start_i <= cur.first;
        page_count_i  <= cur.cnt;
        start         <= 1'b1;
        issued++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor and request predictor
  always @(posedge clk_i) begin
    grant_t g;
    req_t   rq;
    if (rst_ni) begin
      if (done_o) begin
        if (grant_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result: base %h recycled %b status %0d",
                     base_page_o, pool_recycled_o, status_o);
        end else begin
          g = grant_q[0];
          grant_q.delete(0);
          if (base_page_o !== g.base || pool_recycled_o !== g.recycled || status_o !== g.st) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch (exp/act): base %h/%h recycled %b/%b status %0d/%0d",
                       g.base, base_page_o, g.recycled, pool_recycled_o, g.st, status_o);
          end
          if (g.recycled) held_q.delete();
          if (g.alloc && g.st == ST_OK && g.cnt != 0) held_q.push_back({g.base, g.cnt});
        end
      end
      if (start && !busy) begin
        rq.op    = op_e'(operation_i);
        rq.first = range_start_i;
        rq.cnt   = page_count_i;
        grant_q.push_back(serve_request(rq));
        accepted++;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    operation_i   = OP_ALLOC;
    range_start_i = '0;
    page_count_i  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_POOL_START;
    cfg_wdata_i   = '0;
    pool_first    = RESET_POOL_START;
    pool_len      = RESET_POOL_COUNT;
    refill_pool();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset pool: zero-page, exceed, whole pool, wrap, merges, saturation
    request_q.push_back(mk_req(OP_ALLOC, '1, 32'd0));
    request_q.push_back(mk_req(OP_ALLOC, '0, 32'd1));
    request_q.push_back(mk_req(OP_ALLOC, '0, '1));
    request_q.push_back(mk_req(OP_ALLOC, '0, 32'd262144));
    request_q.push_back(mk_req(OP_ALLOC, '0, 32'd1));
    request_q.push_back(mk_req(OP_FREE, '1, '1));
    request_q.push_back(mk_req(OP_FREE, '0, 32'd0));
    request_q.push_back(mk_req(OP_FREE, 52'd262399, 32'd1));
    request_q.push_back(mk_req(OP_FREE, '0, 32'd5));
    request_q.push_back(mk_req(OP_FREE, 52'd16, 32'd240));
    request_q.push_back(mk_req(OP_FREE, 52'hF_FFFF_0000_0000, '1));
    request_q.push_back(mk_req(OP_ALLOC, '0, 32'd3));
    request_q.push_back(mk_req(OP_FREE, 52'd5, 32'd11));
    request_q.push_back(mk_req(OP_ALLOC, '0, 32'd0));
    drain();

    // empty pool
    write_cfg(CFG_POOL_COUNT, '0);
    request_q.push_back(mk_req(OP_ALLOC, '0, '1));
    request_q.push_back(mk_req(OP_ALLOC, '0, 32'd0));
    request_q.push_back(mk_req(OP_ALLOC, '0, 32'd0));
    drain();

    // pool wrapping past the top page number
    write_cfg(CFG_POOL_START, 52'hF_FFFF_FFFF_FC18);
    write_cfg(CFG_POOL_COUNT, {20'($urandom), 32'd4000});
    feed(300, 0, 1'b0);

    write_cfg(CFG_POOL_START, PAGE_W'({$urandom, $urandom}));
    write_cfg(CFG_POOL_COUNT, CFG_DATA_W'($urandom_range(64, 1024)));
    feed(130, 81, 1'b0);
    feed(130, 81, 1'b0);

    write_cfg(CFG_POOL_START, '0);
    write_cfg(CFG_POOL_COUNT, '1);
    feed(250, 23, 1'b0);

    write_cfg(CFG_POOL_START, '1);
    write_cfg(CFG_POOL_COUNT, CFG_DATA_W'(1));
    feed(100, 0, 1'b0);

    // scattered frees until the table overflows
    write_cfg(CFG_POOL_START, PAGE_W'({$urandom, $urandom}));
    write_cfg(CFG_POOL_COUNT, CFG_DATA_W'($urandom_range(100, 300)));
    feed(120, 0, 1'b1);
    feed(250, 81, 1'b0);

    write_cfg(CFG_POOL_START, PAGE_W'({$urandom, $urandom}));
    write_cfg(CFG_POOL_COUNT, {20'($urandom), 32'($urandom)});
    feed(320, 23, 1'b0);

    repeat (2 * RUNS + 20) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("[contiguous_page_run_allocator] OK");
    end else begin
      $display("[contiguous_page_run_allocator] ERROR");
    end
    $finish;
  end

endmodule
